### sv/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants of the random circle packer.
// ----------------------------------------------------------------------------
package rcp_pkg;

	localparam int MAX_CIRCLES = 1024;
	localparam int IDX_W       = $clog2(MAX_CIRCLES);
	localparam int CNT_W       = IDX_W + 1;

	localparam int COORD_W = 16;
	localparam int RAD_W   = 16;
	// Distance of two Q12.4 points: sqrt(2 * 65535^2) needs 17 bits.
	localparam int DIST_W  = RAD_W + 1;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int SQ_W    = PROD_W + 1;
	localparam int ROOT_W  = SQ_W + 1;
	localparam int ROOT_STEPS = (SQ_W + 1) / 2;
	localparam int STEP_W  = $clog2(ROOT_STEPS);

	localparam logic [COORD_W-1:0] SEED_CENTRE = COORD_W'(4000);
	localparam logic [RAD_W-1:0]   SEED_RADIUS = RAD_W'(800);

	localparam logic [RAD_W-1:0] MIN_RADIUS_RST   = RAD_W'(48);
	localparam logic [RAD_W-1:0] MAX_RADIUS_RST   = RAD_W'(800);
	localparam logic [RAD_W-1:0] CANVAS_WIDTH_RST = RAD_W'(8000);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH = CFG_IDX_W'(2);

	typedef enum logic {
		OP_PLACE = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_PLACED  = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [RAD_W-1:0]   r;
	} circle_t;

	localparam circle_t SEED_CIRCLE = '{x: SEED_CENTRE, y: SEED_CENTRE, r: SEED_RADIUS};

endpackage

### sv/rcp_ifs.sv
// ----------------------------------------------------------------------------
// rcp_ifs
// Valid/ready channels of the circle packer: candidate in, result out.
// ----------------------------------------------------------------------------
interface rcp_in_if;
	logic                         valid;
	logic                         ready;
	rcp_pkg::opcode_t             opcode;
	logic [rcp_pkg::COORD_W-1:0]  cand_x;
	logic [rcp_pkg::COORD_W-1:0]  cand_y;

	modport source (output valid, output opcode, output cand_x, output cand_y, input ready);
	modport sink   (input valid, input opcode, input cand_x, input cand_y, output ready);
endinterface

interface rcp_out_if;
	logic                         valid;
	logic                         ready;
	rcp_pkg::status_t             status;
	logic [rcp_pkg::RAD_W-1:0]    placed_radius;
	logic [rcp_pkg::CNT_W-1:0]    circle_total;

	modport source (output valid, output status, output placed_radius, output circle_total,
		input ready);
	modport sink   (input valid, input status, input placed_radius, input circle_total,
		output ready);
endinterface

### sv/random_circle_packer.sv
// ----------------------------------------------------------------------------
// random_circle_packer
// A place transfer offers a candidate centre; the block walks every stored
// circle, measuring the floor Euclidean distance with a shared multiplier and
// a bit-serial square root, rejects the candidate on overlap and otherwise
// appends it with the largest radius that touches no neighbour, capped at
// max_radius. A clear transfer empties the table; after reset it holds one
// seed circle at (250, 250) radius 50. Each stored circle visited goes
// through a table read, an operand load, the squaring of dx and then dy,
// 17 root steps, a wait to see the root finish and a compare; the walk
// stops early when an overlap is found, and clear and table-full items
// skip it. The result goes from S_FIN into the output register. The input
// is not ready while an item is in work; a finished result waits in the
// output register while the next item is taken, and an item whose result
// finds that register still occupied waits until it is taken.
// ----------------------------------------------------------------------------
module random_circle_packer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rcp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rcp_in_if.sink                         req,
	rcp_out_if.source                      rsp
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_LOAD  = 7'b0000100,
		S_WAIT  = 7'b0001000,
		S_CHECK = 7'b0010000,
		S_PLACE = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic [rcp_pkg::RAD_W-1:0]      min_radius_q, max_radius_q, canvas_width_q;
	logic [rcp_pkg::COORD_W-1:0]    cand_x_q, cand_y_q;
	logic [rcp_pkg::RAD_W-1:0]      r_q;
	logic [rcp_pkg::DIST_W-1:0]     best_q;
	logic [rcp_pkg::CNT_W-1:0]      idx_q, count_q;
	rcp_pkg::status_t               res_status_q;
	logic [rcp_pkg::RAD_W-1:0]      res_radius_q;
	logic                           out_valid_q;
	rcp_pkg::status_t               out_status_q;
	logic [rcp_pkg::RAD_W-1:0]      out_radius_q;
	logic [rcp_pkg::CNT_W-1:0]      out_total_q;

	rcp_pkg::circle_t               rdata, wdata;
	logic                           store_we;
	logic                           dist_start, dist_done;
	logic [rcp_pkg::DIST_W-1:0]     distance;
	logic [rcp_pkg::DIST_W-1:0]     thresh, slack;
	logic [rcp_pkg::CNT_W-1:0]      idx_next;
	logic [rcp_pkg::RAD_W-1:0]      new_radius;
	logic                           out_free;

	assign req.ready  = (state_q == S_IDLE);
	assign out_free   = !out_valid_q || rsp.ready;
	assign dist_start = (state_q == S_LOAD);
	assign store_we   = (state_q == S_PLACE);
	assign thresh     = {1'b0, min_radius_q} + {1'b0, r_q};
	assign slack      = distance - {1'b0, r_q};
	assign idx_next   = idx_q + 1'b1;
	assign new_radius = (best_q < {1'b0, max_radius_q}) ?
		best_q[rcp_pkg::RAD_W-1:0] : max_radius_q;
	assign wdata      = '{x: cand_x_q, y: cand_y_q, r: new_radius};

	rcp_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (store_we),
		.waddr  (count_q[rcp_pkg::IDX_W-1:0]),
		.wdata  (wdata),
		.raddr  (idx_q[rcp_pkg::IDX_W-1:0]),
		.rdata  (rdata)
	);

	rcp_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dist_start),
		.ax       (cand_x_q),
		.ay       (cand_y_q),
		.bx       (rdata.x),
		.by       (rdata.y),
		.done     (dist_done),
		.distance (distance)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q   <= rcp_pkg::MIN_RADIUS_RST;
			max_radius_q   <= rcp_pkg::MAX_RADIUS_RST;
			canvas_width_q <= rcp_pkg::CANVAS_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				rcp_pkg::CFG_MIN_RADIUS:   min_radius_q   <= cfg_wdata;
				rcp_pkg::CFG_MAX_RADIUS:   max_radius_q   <= cfg_wdata;
				rcp_pkg::CFG_CANVAS_WIDTH: canvas_width_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cand_x_q     <= '0;
			cand_y_q     <= '0;
			r_q          <= '0;
			best_q       <= '0;
			idx_q        <= '0;
			count_q      <= rcp_pkg::CNT_W'(1);
			res_status_q <= rcp_pkg::ST_PLACED;
			res_radius_q <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= rcp_pkg::ST_PLACED;
			out_radius_q <= '0;
			out_total_q  <= '0;
		end else begin
			// In S_FIN the output register is either reloaded or left waiting.
			if (rsp.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cand_x_q     <= req.cand_x;
						cand_y_q     <= req.cand_y;
						res_radius_q <= '0;
						best_q       <= {1'b0, canvas_width_q};
						idx_q        <= '0;
						if (req.opcode == rcp_pkg::OP_CLEAR) begin
							count_q      <= '0;
							res_status_q <= rcp_pkg::ST_CLEARED;
							state_q      <= S_FIN;
						end else if (count_q == rcp_pkg::CNT_W'(rcp_pkg::MAX_CIRCLES)) begin
							res_status_q <= rcp_pkg::ST_FULL;
							state_q      <= S_FIN;
						end else if (count_q == '0) begin
							state_q <= S_PLACE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					r_q     <= rdata.r;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (dist_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (distance < thresh) begin
						res_status_q <= rcp_pkg::ST_OVERLAP;
						state_q      <= S_FIN;
					end else begin
						if (slack < best_q) begin
							best_q <= slack;
						end
						idx_q   <= idx_next;
						state_q <= (idx_next == count_q) ? S_PLACE : S_READ;
					end
				end
				S_PLACE: begin
					count_q      <= count_q + 1'b1;
					res_status_q <= rcp_pkg::ST_PLACED;
					res_radius_q <= new_radius;
					state_q      <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_radius_q <= res_radius_q;
						out_total_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.placed_radius = out_radius_q;
	assign rsp.circle_total  = out_total_q;

endmodule

### sv/rcp_store.sv
// ----------------------------------------------------------------------------
// rcp_store
// Circle table: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rcp_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [rcp_pkg::IDX_W-1:0]   waddr,
	input  rcp_pkg::circle_t            wdata,
	input  logic [rcp_pkg::IDX_W-1:0]   raddr,
	output rcp_pkg::circle_t            rdata
);

	rcp_pkg::circle_t mem [rcp_pkg::MAX_CIRCLES];
	rcp_pkg::circle_t rd_q;
	logic             seed_q;
	logic             seed_rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Entry 0 reads as the seed circle until it is first overwritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= 1'b1;
			seed_rd_q <= 1'b0;
		end else begin
			if (we && waddr == '0) begin
				seed_q <= 1'b0;
			end
			seed_rd_q <= seed_q && (raddr == '0);
		end
	end

	assign rdata = seed_rd_q ? rcp_pkg::SEED_CIRCLE : rd_q;

endmodule

### sv/rcp_dist.sv
// ----------------------------------------------------------------------------
// rcp_dist
// Distance unit: one shared 16x16 multiplier squares dx then dy, then a
// restoring square root takes one result bit per cycle.
// ----------------------------------------------------------------------------
module rcp_dist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rcp_pkg::COORD_W-1:0]   ax,
	input  logic [rcp_pkg::COORD_W-1:0]   ay,
	input  logic [rcp_pkg::COORD_W-1:0]   bx,
	input  logic [rcp_pkg::COORD_W-1:0]   by,
	output logic                          done,
	output logic [rcp_pkg::DIST_W-1:0]    distance
);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_SQX  = 4'b0010,
		D_SQY  = 4'b0100,
		D_ROOT = 4'b1000
	} dstate_t;

	localparam logic [rcp_pkg::ROOT_W-1:0] ROOT_TOP =
		rcp_pkg::ROOT_W'(1) << (2 * (rcp_pkg::ROOT_STEPS - 1));

	dstate_t                        state_q;
	logic [rcp_pkg::COORD_W-1:0]    dx_q, dy_q;
	logic [rcp_pkg::PROD_W-1:0]     acc_q;
	logic [rcp_pkg::SQ_W-1:0]       rem_q;
	logic [rcp_pkg::ROOT_W-1:0]     res_q;
	logic [rcp_pkg::ROOT_W-1:0]     bit_q;
	logic [rcp_pkg::STEP_W-1:0]     cnt_q;
	logic                           done_q;

	logic [rcp_pkg::COORD_W-1:0]    mop;
	logic [rcp_pkg::PROD_W-1:0]     prod;
	logic [rcp_pkg::SQ_W-1:0]       sum;
	logic [rcp_pkg::ROOT_W-1:0]     trial;
	logic                           fits;

	assign mop   = (state_q == D_SQX) ? dx_q : dy_q;
	assign prod  = mop * mop;
	assign sum   = {1'b0, acc_q} + {1'b0, prod};
	assign trial = res_q + bit_q;
	assign fits  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			dx_q    <= '0;
			dy_q    <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						dx_q    <= (ax >= bx) ? ax - bx : bx - ax;
						dy_q    <= (ay >= by) ? ay - by : by - ay;
						state_q <= D_SQX;
					end
				end
				D_SQX: begin
					acc_q   <= prod;
					state_q <= D_SQY;
				end
				D_SQY: begin
					rem_q   <= sum;
					res_q   <= '0;
					bit_q   <= ROOT_TOP;
					cnt_q   <= rcp_pkg::STEP_W'(rcp_pkg::ROOT_STEPS - 1);
					state_q <= D_ROOT;
				end
				D_ROOT: begin
					if (fits) begin
						rem_q <= rem_q - trial[rcp_pkg::SQ_W-1:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign distance = res_q[rcp_pkg::DIST_W-1:0];

endmodule

### tb/sv/rcp_placement_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcp_placement_checker
// Watches the candidate, result and register channels of the circle packer.
// It keeps its own copy of the circle table and registers, works out the
// outcome of every accepted candidate, and compares each result transfer with
// the oldest outcome still outstanding.
// ----------------------------------------------------------------------------
module rcp_placement_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rcp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rcp_in_if                              req,
	rcp_out_if                             rsp,
	output int                             fail_count,
	output int                             backlog
);
	import rcp_pkg::*;

	typedef struct packed {
		status_t          status;
		logic [RAD_W-1:0] radius;
		logic [CNT_W-1:0] total;
	} outcome_t;

	logic [RAD_W-1:0] min_radius;
	logic [RAD_W-1:0] max_radius;
	logic [RAD_W-1:0] canvas_width;
	circle_t          circle_tab [MAX_CIRCLES];
	int               circle_cnt;
	outcome_t         outcome_q [$];
	outcome_t         oldest;

	function automatic int unsigned floor_root(longint unsigned v);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		for (int b = 17; b >= 0; b--) begin
			probe = root | (64'd1 << b);
			if (probe * probe <= v)
				root = probe;
		end
		return int'(root);
	endfunction

	// Updates the table as the block should and returns the outcome of one item.
	function automatic outcome_t place_or_clear(opcode_t op, logic [COORD_W-1:0] x,
		logic [COORD_W-1:0] y);
		outcome_t        o;
		longint unsigned dx;
		longint unsigned dy;
		int unsigned     distance;
		int unsigned     rad;
		int unsigned     best;
		bit              hit;
		o.status = ST_PLACED;
		o.radius = '0;
		if (op == OP_CLEAR) begin
			circle_cnt = 0;
			o.status = ST_CLEARED;
		end else if (circle_cnt >= MAX_CIRCLES) begin
			o.status = ST_FULL;
		end else begin
			hit = 1'b0;
			best = canvas_width;
			for (int k = 0; k < circle_cnt; k++) begin
				dx = (x > circle_tab[k].x) ? x - circle_tab[k].x : circle_tab[k].x - x;
				dy = (y > circle_tab[k].y) ? y - circle_tab[k].y : circle_tab[k].y - y;
				distance = floor_root(dx * dx + dy * dy);
				rad = circle_tab[k].r;
				if (distance < int'(min_radius) + rad) begin
					hit = 1'b1;
					break;
				end
				if (distance - rad < best)
					best = distance - rad;
			end
			if (hit) begin
				o.status = ST_OVERLAP;
			end else begin
				if (best > max_radius)
					best = max_radius;
				o.radius = best[RAD_W-1:0];
				circle_tab[circle_cnt] = '{x: x, y: y, r: best[RAD_W-1:0]};
				circle_cnt++;
			end
		end
		o.total = circle_cnt[CNT_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius   = MIN_RADIUS_RST;
			max_radius   = MAX_RADIUS_RST;
			canvas_width = CANVAS_WIDTH_RST;
			for (int k = 0; k < MAX_CIRCLES; k++)
				circle_tab[k] = '0;
			circle_tab[0] = SEED_CIRCLE;
			circle_cnt = 1;
			outcome_q.delete();
			fail_count = 0;
			backlog = 0;
		end else begin
			// A result leaving now belongs to an item taken at an earlier edge.
			if (rsp.valid && rsp.ready) begin
				if (outcome_q.size() == 0) begin
					$error("result transfer with nothing outstanding: status %0d", rsp.status);
					fail_count++;
				end else begin
					oldest = outcome_q.pop_front();
					if (rsp.status !== oldest.status) begin
						$error("status: expected %0d, actual %0d", oldest.status, rsp.status);
						fail_count++;
					end
					if (rsp.placed_radius !== oldest.radius) begin
						$error("placed_radius: expected %0d, actual %0d", oldest.radius,
							rsp.placed_radius);
						fail_count++;
					end
					if (rsp.circle_total !== oldest.total) begin
						$error("circle_total: expected %0d, actual %0d", oldest.total,
							rsp.circle_total);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MIN_RADIUS:   min_radius = cfg_wdata;
					CFG_MAX_RADIUS:   max_radius = cfg_wdata;
					CFG_CANVAS_WIDTH: canvas_width = cfg_wdata;
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				outcome_q = {outcome_q, place_or_clear(req.opcode, req.cand_x, req.cand_y)};
			backlog = outcome_q.size();
		end
	end

endmodule

### tb/sv/random_circle_packer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// random_circle_packer_tb
// Drives candidate and clear items into the circle packer under random
// sender gaps and receiver stalls. A directed part probes the seed circle,
// the exact touching distance, corner coordinates, clears and register
// extremes; random phases then mix clustered and spread candidates under
// several register settings. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module random_circle_packer_tb;
	import rcp_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 13;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fails;
	int                    backlog;
	int                    cycles = 0;
	bit                    send_burst = 1'b0;
	bit                    take_burst = 1'b0;
	logic [COORD_W-1:0]    recent_x [$];
	logic [COORD_W-1:0]    recent_y [$];

	rcp_in_if  req_ch ();
	rcp_out_if rsp_ch ();

	random_circle_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	rcp_placement_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fails),
		.backlog    (backlog)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("random_circle_packer_tb NOT OK");
			$finish;
		end
	end

	// Result side: a fresh stall before every transfer unless in a burst phase.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = take_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	task automatic offer(opcode_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.cand_x <= x;
		req_ch.cand_y <= y;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
	endtask

	// Holds the sender off until every outstanding result has been taken.
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic load_config(logic [RAD_W-1:0] mn, logic [RAD_W-1:0] mx,
		logic [RAD_W-1:0] cw);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_MIN_RADIUS;
		cfg_wdata <= mn;
		@(posedge clk);
		cfg_idx   <= CFG_MAX_RADIUS;
		cfg_wdata <= mx;
		@(posedge clk);
		cfg_idx   <= CFG_CANVAS_WIDTH;
		cfg_wdata <= cw;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic phase_config(int kind);
		case (kind)
			0: load_config(MIN_RADIUS_RST, MAX_RADIUS_RST, CANVAS_WIDTH_RST);
			2: load_config('0, '1, '1);
			3: load_config('1, '0, '0);
			4: load_config(RAD_W'($urandom), RAD_W'($urandom), RAD_W'($urandom));
			default: load_config(RAD_W'($urandom_range(0, 256)),
				RAD_W'($urandom_range(16, 4000)), RAD_W'($urandom_range(0, 12000)));
		endcase
	endtask

	// Candidates land near earlier ones, in a crowded corner, or anywhere.
	task automatic pick_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
		int sel;
		int k;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			k = $urandom_range(0, recent_x.size() - 1);
			x = recent_x[k] + COORD_W'($urandom_range(0, 3000)) - COORD_W'(1500);
			y = recent_y[k] + COORD_W'($urandom_range(0, 3000)) - COORD_W'(1500);
		end else if (sel < 7) begin
			x = COORD_W'($urandom_range(0, 12000));
			y = COORD_W'($urandom_range(0, 12000));
		end else begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end
		recent_x = {recent_x, x};
		recent_y = {recent_y, y};
		if (recent_x.size() > 16) begin
			recent_x.pop_front();
			recent_y.pop_front();
		end
	endtask

	initial begin
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_idx       <= CFG_MIN_RADIUS;
		cfg_wdata     <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.opcode <= OP_PLACE;
		req_ch.cand_x <= '0;
		req_ch.cand_y <= '0;
		recent_x = {recent_x, SEED_CENTRE};
		recent_y = {recent_y, SEED_CENTRE};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed circle hit dead center, one unit inside contact, then exact contact.
		offer(OP_PLACE, SEED_CENTRE, SEED_CENTRE);
		offer(OP_PLACE, COORD_W'(4847), SEED_CENTRE);
		offer(OP_PLACE, COORD_W'(4848), SEED_CENTRE);
		offer(OP_PLACE, '0, '0);
		offer(OP_PLACE, '1, '1);
		offer(OP_PLACE, '1, '0);
		offer(OP_PLACE, '0, '1);
		offer(OP_PLACE, COORD_W'(16'hAAAA), COORD_W'(16'h5555));
		offer(OP_PLACE, COORD_W'(16'h5555), COORD_W'(16'hAAAA));
		offer(OP_CLEAR, '1, '1);
		// An empty table accepts anything.
		offer(OP_PLACE, SEED_CENTRE, SEED_CENTRE);
		offer(OP_PLACE, SEED_CENTRE, SEED_CENTRE);
		offer(OP_CLEAR, '0, '0);
		offer(OP_CLEAR, '0, '0);

		settle();
		load_config('0, '1, '1);
		offer(OP_PLACE, COORD_W'(1000), COORD_W'(1000));
		offer(OP_PLACE, COORD_W'(1000), COORD_W'(1000));
		offer(OP_PLACE, '1, '1);
		offer(OP_CLEAR, '0, '0);
		offer(OP_PLACE, '0, '0);

		settle();
		load_config('1, '0, '0);
		offer(OP_CLEAR, '0, '0);
		offer(OP_PLACE, '0, '0);
		offer(OP_PLACE, '1, '1);
		offer(OP_PLACE, COORD_W'(30000), COORD_W'(30000));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			phase_config(ph);
			send_burst = ($urandom_range(0, 3) == 0);
			take_burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 7) == 0)
					settle();
				if ($urandom_range(0, 9) == 0) begin
					offer(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
				end else begin
					pick_point(px, py);
					offer(OP_PLACE, px, py);
				end
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (fails == 0 && backlog == 0)
			$display("random_circle_packer_tb OK");
		else
			$display("random_circle_packer_tb NOT OK");
		$finish;
	end

endmodule

### sim.f
sv/rcp_pkg.sv
sv/rcp_ifs.sv
sv/rcp_store.sv
sv/rcp_dist.sv
sv/random_circle_packer.sv
tb/sv/rcp_placement_checker.sv
tb/sv/random_circle_packer_tb.sv
